// ===== rtl/plt_pkg.sv =====
// Shared types and constants for the palette nearest-colour mapper.
package plt_pkg;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_MAP  = 1'b1
   } plt_cmd_type;

   typedef struct packed {
      plt_cmd_type cmd;
      logic [7:0]  slot;
      logic [7:0]  alpha;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
   } plt_job_type;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CHAN_W      = 8;
   localparam int SQ_W        = 2 * CHAN_W;
   localparam int DIST_W      = 18;
   localparam int COUNT_W     = 9;
   localparam int INDEX_W     = 8;

endpackage

// ===== rtl/palette_nearest_color_map.sv =====
// With the back end idle, a load word goes from the job queue into the palette memory, and a map
// word passes through the job queue and the address, read-data and squared-difference registers
// before the result is registered. Loads go one per cycle while the back end is idle; a map word
// waits until the last result is popped. One entry is compared per cycle in one distance unit.
// Reset clears the queue, the scan control and the result; the count register returns to one.
// Palette entries are undefined after reset until they are loaded.
module palette_nearest_color_map import plt_pkg::*; #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_command,
   input  logic [7:0]  req_entry_index,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_alpha,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [7:0]  rsp_match_index,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic [7:0]  rsp_out_alpha,
   input  logic        csr_write_en,
   input  logic [8:0]  csr_write_data
);

   plt_job_type job;
   logic        job_valid;
   logic        job_take;

   plt_front #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_command     (req_command),
      .req_entry_index (req_entry_index),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_alpha       (req_alpha),
      .job_valid       (job_valid),
      .job             (job),
      .job_take        (job_take)
   );

   plt_back #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .job_valid       (job_valid),
      .job             (job),
      .job_take        (job_take),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_match_index (rsp_match_index),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_out_alpha   (rsp_out_alpha)
   );

endmodule

// ===== rtl/plt_front.sv =====
// Front end: accepts request words, classifies them and queues jobs for the back end.
module plt_front import plt_pkg::*; #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_command,
   input  logic [7:0]  req_entry_index,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_alpha,
   output logic        job_valid,
   output plt_job_type job,
   input  logic        job_take
);

   plt_job_type              queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]        wr_ptr_ff;
   logic [QPTR_W-1:0]        rd_ptr_ff;
   logic [QCNT_W-1:0]        count_ff;
   plt_job_type              job_in;
   logic                     accept;
   logic                     slot_ok;
   logic                     keep;
   logic                     take;

   assign req_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign job_valid = (count_ff != '0);
   assign job       = queue_ff[rd_ptr_ff];
   assign accept    = req_push && !req_full;
   assign take      = job_take && job_valid;
   assign slot_ok   = (32'(req_entry_index) < 32'(PALETTE_DEPTH));

   // A transparent pixel is searched as all-zero; loads to absent slots are dropped.
   always_comb begin
      job_in.cmd   = plt_cmd_type'(req_command);
      job_in.slot  = req_entry_index;
      job_in.alpha = req_alpha;
      if ((job_in.cmd == CMD_MAP) && (req_alpha == '0)) begin
         job_in.red   = '0;
         job_in.green = '0;
         job_in.blue  = '0;
      end else begin
         job_in.red   = req_red;
         job_in.green = req_green;
         job_in.blue  = req_blue;
      end
      keep = accept && ((job_in.cmd == CMD_MAP) || slot_ok);
   end

   always_ff @(posedge clock) begin
      if (keep) begin
         queue_ff[wr_ptr_ff] <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (keep) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (take) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + QCNT_W'(keep) - QCNT_W'(take);
      end
   end

endmodule

// ===== rtl/plt_back.sv =====
// Back end: palette memory, pipelined distance scan and result register.
module plt_back import plt_pkg::*; #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [COUNT_W-1:0] csr_write_data,
   input  logic               job_valid,
   input  plt_job_type        job,
   output logic               job_take,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output logic [7:0]         rsp_match_index,
   output logic [7:0]         rsp_out_red,
   output logic [7:0]         rsp_out_green,
   output logic [7:0]         rsp_out_blue,
   output logic [7:0]         rsp_out_alpha
);

   localparam int AW = $clog2(PALETTE_DEPTH);
   localparam int CW = ($clog2(PALETTE_DEPTH + 1) > COUNT_W) ?
                       $clog2(PALETTE_DEPTH + 1) : COUNT_W;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   logic [31:0]                 mem [PALETTE_DEPTH];
   state_type                   state_ff;
   logic [COUNT_W-1:0]          count_ff;
   logic [3:0][CHAN_W-1:0]      pix_ff;
   logic [AW-1:0]               addr_ff;
   logic [AW-1:0]               last_addr_ff;
   logic                        issue_ff;
   logic                        v1_ff;
   logic                        last1_ff;
   logic [AW-1:0]               idx1_ff;
   logic [31:0]                 rd_data_ff;
   logic                        v2_ff;
   logic                        last2_ff;
   logic [AW-1:0]               idx2_ff;
   logic [31:0]                 color2_ff;
   logic [3:0][SQ_W-1:0]        sq2_ff;
   logic                        first_ff;
   logic [DIST_W-1:0]           best_dist_ff;
   logic [AW-1:0]               best_idx_ff;
   logic [31:0]                 best_color_ff;
   logic                        rsp_valid_ff;
   logic [INDEX_W-1:0]          rsp_idx_ff;
   logic [31:0]                 rsp_color_ff;

   logic [CW-1:0]               limit;
   logic [AW-1:0]               last_addr_in;
   logic [3:0][SQ_W-1:0]        sq_in;
   logic [CHAN_W-1:0]           diff;
   logic [CHAN_W-1:0]           ent;
   logic [DIST_W-1:0]           cand_dist;
   logic                        better;
   logic [AW-1:0]               win_idx;
   logic [31:0]                 win_color;
   logic                        mem_we;

   assign job_take = job_valid && (state_ff == S_IDLE) &&
                     ((job.cmd == CMD_LOAD) || !rsp_valid_ff);
   assign mem_we   = job_take && (job.cmd == CMD_LOAD);

   // The searched range is the register value, forced into one to the palette depth.
   always_comb begin
      limit = CW'(count_ff);
      if (limit == '0) begin
         limit = CW'(1);
      end
      if (limit > CW'(PALETTE_DEPTH)) begin
         limit = CW'(PALETTE_DEPTH);
      end
      last_addr_in = AW'(limit - CW'(1));
   end

   always_comb begin
      diff = '0;
      ent  = '0;
      for (int k = 0; k < 4; k++) begin
         ent = rd_data_ff[k*CHAN_W +: CHAN_W];
         diff = (ent > pix_ff[k]) ? (ent - pix_ff[k]) : (pix_ff[k] - ent);
         sq_in[k] = SQ_W'(diff) * SQ_W'(diff);
      end
   end

   always_comb begin
      cand_dist = DIST_W'(sq2_ff[0]) + DIST_W'(sq2_ff[1]) +
                  DIST_W'(sq2_ff[2]) + DIST_W'(sq2_ff[3]);
      better = first_ff || (cand_dist < best_dist_ff);
      win_idx   = better ? idx2_ff : best_idx_ff;
      win_color = better ? color2_ff : best_color_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[AW'(job.slot)] <= {job.alpha, job.blue, job.green, job.red};
      end
      rd_data_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      idx1_ff   <= addr_ff;
      last1_ff  <= (addr_ff == last_addr_ff);
      idx2_ff   <= idx1_ff;
      last2_ff  <= last1_ff;
      color2_ff <= rd_data_ff;
      sq2_ff    <= sq_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= COUNT_W'(1);
         issue_ff     <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            count_ff <= csr_write_data;
         end
         v1_ff <= issue_ff;
         v2_ff <= v1_ff;
         if (rsp_pop && rsp_valid_ff) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (job_take && (job.cmd == CMD_MAP)) begin
                  state_ff     <= S_SCAN;
                  issue_ff     <= 1'b1;
                  addr_ff      <= '0;
                  last_addr_ff <= last_addr_in;
                  pix_ff       <= {job.alpha, job.blue, job.green, job.red};
                  first_ff     <= 1'b1;
               end
            end
            S_SCAN: begin
               if (issue_ff) begin
                  addr_ff <= addr_ff + 1'b1;
                  if (addr_ff == last_addr_ff) begin
                     issue_ff <= 1'b0;
                  end
               end
               if (v2_ff) begin
                  first_ff      <= 1'b0;
                  best_dist_ff  <= better ? cand_dist : best_dist_ff;
                  best_idx_ff   <= win_idx;
                  best_color_ff <= win_color;
                  if (last2_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_idx_ff   <= INDEX_W'(win_idx);
                     rsp_color_ff <= win_color;
                     state_ff     <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_empty       = !rsp_valid_ff;
   assign rsp_match_index = rsp_idx_ff;
   assign rsp_out_red     = rsp_color_ff[7:0];
   assign rsp_out_green   = rsp_color_ff[15:8];
   assign rsp_out_blue    = rsp_color_ff[23:16];
   assign rsp_out_alpha   = rsp_color_ff[31:24];

endmodule

// ===== rtl/plt_checker.sv =====
// Port-level checks for the palette mapper, bound to the top level.
module plt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_pop,
   input logic       rsp_empty,
   input logic [7:0] rsp_match_index,
   input logic [7:0] rsp_out_red,
   input logic [7:0] rsp_out_green,
   input logic [7:0] rsp_out_blue,
   input logic [7:0] rsp_out_alpha
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queue or result not cleared by reset");

   a_no_early_word: assert property (@(posedge clock)
      reset |=> rsp_empty ##1 rsp_empty ##1 rsp_empty)
      else $error("result word appeared too soon after reset");

   a_word_held: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("waiting result word withdrawn");

   a_word_stable: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(rsp_match_index) && $stable(rsp_out_red) &&
         $stable(rsp_out_green) && $stable(rsp_out_blue) && $stable(rsp_out_alpha))
      else $error("waiting result word changed");

endmodule

bind palette_nearest_color_map plt_checker u_plt_checker (.*);

// ===== tb/sv/tb_palette_nearest_color_map.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the palette nearest-colour mapper, with its own colour predictor.
module tb_palette_nearest_color_map import plt_pkg::*; ();

   localparam int PALETTE_DEPTH = 256;
   localparam int HALF_PERIOD   = 10;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rgba_type;

   typedef struct packed {
      logic [7:0] index;
      rgba_type   colour;
   } colour_match_type;

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_push        = 1'b0;
   logic       req_full;
   logic       req_command     = 1'b0;
   logic [7:0] req_entry_index = 8'd0;
   logic [7:0] req_red         = 8'd0;
   logic [7:0] req_green       = 8'd0;
   logic [7:0] req_blue        = 8'd0;
   logic [7:0] req_alpha       = 8'd0;
   logic       rsp_pop         = 1'b0;
   logic       rsp_empty;
   logic [7:0] rsp_match_index;
   logic [7:0] rsp_out_red;
   logic [7:0] rsp_out_green;
   logic [7:0] rsp_out_blue;
   logic [7:0] rsp_out_alpha;
   logic       csr_write_en    = 1'b0;
   logic [8:0] csr_write_data  = 9'd0;

   rgba_type         palette_model [PALETTE_DEPTH];
   logic [8:0]       count_model = 9'd1;
   colour_match_type expected_matches [$];

   bit sender_steady   = 1'b0;
   bit receiver_steady = 1'b0;
   int hold_request    = 0;
   int stall_left      = 0;

   int errors          = 0;
   int loads_sent      = 0;
   int maps_sent       = 0;
   int blank_maps      = 0;
   int results_checked = 0;
   int count_writes    = 0;
   int full_cycles     = 0;

   palette_nearest_color_map #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_command    (req_command),
      .req_entry_index(req_entry_index),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .req_alpha      (req_alpha),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_match_index(rsp_match_index),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue),
      .rsp_out_alpha  (rsp_out_alpha),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic rgba_type rgba(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic [7:0] a);
      return {r, g, b, a};
   endfunction

   function automatic int scan_length();
      if (count_model == 9'd0) return 1;
      if (count_model > PALETTE_DEPTH) return PALETTE_DEPTH;
      return int'(count_model);
   endfunction

   function automatic int sq_gap(logic [7:0] x, logic [7:0] y);
      int d;
      d = (x > y) ? int'(x) - int'(y) : int'(y) - int'(x);
      return d * d;
   endfunction

   function automatic int colour_distance(rgba_type e, rgba_type px);
      return sq_gap(e.red, px.red) + sq_gap(e.green, px.green)
           + sq_gap(e.blue, px.blue) + sq_gap(e.alpha, px.alpha);
   endfunction

   function automatic colour_match_type nearest_colour(rgba_type px);
      colour_match_type result;
      int span;
      int best_dist;
      int cand_dist;
      if (px.alpha == 8'd0) px = '0;
      span = scan_length();
      result.index = 8'd0;
      best_dist = colour_distance(palette_model[0], px);
      for (int j = 1; j < span; j++) begin
         cand_dist = colour_distance(palette_model[j], px);
         if (cand_dist < best_dist) begin
            best_dist = cand_dist;
            result.index = 8'(j);
         end
      end
      result.colour = palette_model[result.index];
      return result;
   endfunction

   function automatic int idle_gap(bit steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic rgba_type random_colour();
      rgba_type c;
      c = $urandom;
      return c;
   endfunction

   function automatic logic [7:0] extreme();
      return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
   endfunction

   function automatic logic [7:0] nudge(logic [7:0] ch);
      int v;
      v = int'(ch) + int'($urandom_range(0, 6)) - 3;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   function automatic rgba_type random_pixel();
      rgba_type px;
      int r;
      r = $urandom_range(0, 99);
      px = random_colour();
      if (r < 25) begin
         px = palette_model[$urandom_range(0, scan_length() - 1)];
         px = rgba(nudge(px.red), nudge(px.green), nudge(px.blue), nudge(px.alpha));
      end else if (r < 35) begin
         px.alpha = 8'd0;
      end else if (r < 50) begin
         px = rgba(extreme(), extreme(), extreme(), extreme());
      end
      return px;
   endfunction

   function automatic logic [7:0] random_slot();
      if ($urandom_range(0, 99) < 60) return 8'($urandom_range(0, scan_length() - 1));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic rgba_type random_entry();
      if ($urandom_range(0, 99) < 20) return palette_model[$urandom_range(0, scan_length() - 1)];
      return random_colour();
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endfunction

   task automatic send_word(plt_cmd_type cmd, logic [7:0] slot, rgba_type colour);
      int gap;
      gap = idle_gap(sender_steady);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push        <= 1'b1;
      req_command     <= cmd;
      req_entry_index <= slot;
      req_red         <= colour.red;
      req_green       <= colour.green;
      req_blue        <= colour.blue;
      req_alpha       <= colour.alpha;
      @(posedge clock);
      while (req_full) begin
         full_cycles++;
         @(posedge clock);
      end
      if (cmd == CMD_LOAD) begin
         palette_model[slot] = colour;
         loads_sent++;
      end else begin
         if (colour.alpha == 8'd0) blank_maps++;
         expected_matches.push_back(nearest_colour(colour));
         maps_sent++;
      end
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (scan_length() + 10) @(posedge clock);
   endtask

   task automatic write_count(logic [8:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      count_model = value;
      count_writes++;
   endtask

   task automatic test_reset_count();
      send_word(CMD_LOAD, 8'd0, rgba(8'h12, 8'h34, 8'h56, 8'h78));
      send_word(CMD_MAP, 8'hFF, rgba(8'hFF, 8'hFF, 8'hFF, 8'h00));
      send_word(CMD_MAP, 8'h00, rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));
      wait_idle();
      write_count(9'd0);
      send_word(CMD_MAP, 8'hA5, random_colour());
      wait_idle();
   endtask

   task automatic test_small_palette();
      send_word(CMD_LOAD, 8'd1, rgba(8'd0, 8'd0, 8'd0, 8'd0));
      send_word(CMD_LOAD, 8'd2, rgba(8'd255, 8'd255, 8'd255, 8'd255));
      send_word(CMD_LOAD, 8'd3, rgba(8'd255, 8'd255, 8'd255, 8'd255));
      send_word(CMD_LOAD, 8'd4, rgba(8'd255, 8'd0, 8'd0, 8'd255));
      send_word(CMD_LOAD, 8'd5, rgba(8'd0, 8'd255, 8'd0, 8'd255));
      send_word(CMD_LOAD, 8'd6, rgba(8'd0, 8'd0, 8'd255, 8'd255));
      send_word(CMD_LOAD, 8'd7, rgba(8'h12, 8'h34, 8'h56, 8'h78));
      wait_idle();
      write_count(9'd8);
      send_word(CMD_MAP, 8'd0, rgba(8'd255, 8'd255, 8'd255, 8'd255));
      send_word(CMD_MAP, 8'd0, rgba(8'd255, 8'd128, 8'd7, 8'd0));
      send_word(CMD_MAP, 8'd0, rgba(8'h12, 8'h34, 8'h56, 8'h78));
      send_word(CMD_MAP, 8'd0, rgba(8'd200, 8'd10, 8'd10, 8'd250));
      send_word(CMD_MAP, 8'd0, rgba(8'd0, 8'd0, 8'd0, 8'd255));
      wait_idle();
      write_count(9'd3);
      send_word(CMD_MAP, 8'd0, rgba(8'd0, 8'd0, 8'd250, 8'd255));
      wait_idle();
   endtask

   task automatic test_full_palette();
      for (int s = 0; s < PALETTE_DEPTH; s++) send_word(CMD_LOAD, 8'(s), random_colour());
      wait_idle();
      write_count(9'd256);
      repeat (8) send_word(CMD_MAP, 8'($urandom), random_pixel());
      wait_idle();
      write_count(9'h1FF);
      repeat (8) send_word(CMD_MAP, 8'($urandom), random_pixel());
      wait_idle();
      write_count(9'd300);
      repeat (4) send_word(CMD_MAP, 8'($urandom), random_pixel());
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int r;
      int burst;
      logic [8:0] count;
      for (int phase = 0; phase < 28; phase++) begin
         r = $urandom_range(0, 99);
         if (r < 3) count = 9'd0;
         else if (r < 70) count = 9'($urandom_range(1, 16));
         else if (r < 90) count = 9'($urandom_range(17, 64));
         else if (r < 97) count = 9'($urandom_range(65, 256));
         else count = 9'($urandom_range(257, 511));
         write_count(count);
         sender_steady   = (phase % 4 == 1);
         receiver_steady = (phase % 4 == 2);
         burst = $urandom_range(35, 60);
         repeat (burst) begin
            if ($urandom_range(0, 99) < 70) send_word(CMD_MAP, 8'($urandom), random_pixel());
            else send_word(CMD_LOAD, random_slot(), random_entry());
         end
         wait_idle();
      end
      sender_steady   = 1'b0;
      receiver_steady = 1'b0;
   endtask

   // The receiver holds off long enough for the queue to fill and stall the sender.
   task automatic test_backpressure();
      write_count(9'd4);
      sender_steady = 1'b1;
      hold_request  = 300;
      repeat (20) send_word(CMD_MAP, 8'($urandom), random_pixel());
      wait_idle();
      sender_steady = 1'b0;
   endtask

   always @(posedge clock) begin : result_drain
      if (hold_request > 0) begin
         stall_left   = hold_request;
         hold_request = 0;
      end else if (stall_left == 0 && rsp_pop && !rsp_empty) begin
         stall_left = idle_gap(receiver_steady);
      end
      if (stall_left > 0) begin
         rsp_pop <= 1'b0;
         stall_left--;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      colour_match_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_matches.size() == 0) begin
            $error("result word with no map word outstanding: match_index %0d",
                   rsp_match_index);
            errors++;
         end else begin
            want = expected_matches.pop_front();
            results_checked++;
            check_field("match_index", want.index, rsp_match_index);
            check_field("out_red", want.colour.red, rsp_out_red);
            check_field("out_green", want.colour.green, rsp_out_green);
            check_field("out_blue", want.colour.blue, rsp_out_blue);
            check_field("out_alpha", want.colour.alpha, rsp_out_alpha);
         end
      end
   end

   initial begin : run
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_count();
      test_small_palette();
      test_full_palette();
      test_random_traffic();
      test_backpressure();
      if (expected_matches.size() != 0) begin
         $error("%0d expected results never arrived", expected_matches.size());
         errors++;
      end
      $display("Sent %0d load words and %0d map words (%0d with zero alpha); %0d results checked.",
               loads_sent, maps_sent, blank_maps, results_checked);
      $display("Wrote the count register %0d times; input held by a full queue for %0d cycles.",
               count_writes, full_cycles);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #40_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
